>>> hw/rtl/rte_pkg.sv
// Shared types and constants for the rotary encoder time setter.
// Word structs for both channels, pin and step codes, saturating update helper.
// No dependencies.
package rte_pkg;

  localparam logic [1:0] FUNC_CAPTURE = 2'd0;
  localparam logic [1:0] FUNC_ROTATE  = 2'd1;
  localparam logic [1:0] FUNC_LOAD    = 2'd2;
  localparam logic [1:0] FUNC_NONE    = 2'd3;

  localparam logic [1:0] PINS_LOW  = 2'b00;
  localparam logic [1:0] PINS_B    = 2'b01;
  localparam logic [1:0] PINS_A    = 2'b10;
  localparam logic [1:0] PINS_HIGH = 2'b11;

  localparam logic [1:0] STEP_NONE = 2'd0;
  localparam logic [1:0] STEP_UP   = 2'd1;
  localparam logic [1:0] STEP_DOWN = 2'd2;

  localparam logic [1:0] SEL_HOURS   = 2'd0;
  localparam logic [1:0] SEL_MINUTES = 2'd1;
  localparam logic [1:0] SEL_SECONDS = 2'd2;

  localparam logic [5:0] HOURS_MAX   = 6'd23;
  localparam logic [5:0] MINUTES_MAX = 6'd59;

  localparam logic [15:0] HOLDOFF_RESET = 16'd100;

  typedef struct packed {
    logic [1:0]  func;
    logic        pin_a;
    logic        pin_b;
    logic [31:0] now_ms;
    logic        vertical_mode;
    logic        horizontal_mode;
    logic [1:0]  field_select;
    logic [4:0]  load_hours;
    logic [5:0]  load_minutes;
    logic [5:0]  load_seconds;
  } in_t;

  typedef struct packed {
    logic       menu_pointer;
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic [1:0] step;
  } out_t;

  typedef struct packed {
    logic [1:0] pins;
    logic       pointer;
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
  } state_t;

  function automatic logic [5:0] bump(input logic [5:0] v, input logic [5:0] limit,
                                      input logic up);
    logic [5:0] r;
    r = v;
    if (up) begin
      if (v < limit) r = v + 6'd1;
    end else begin
      if (v != 6'd0 && v <= limit) r = v - 6'd1;
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/rte_step_logic.sv
// Per-word update logic: quadrature decode, hold-off check and field update.
// Purely combinational; depends on rte_pkg.
module rte_step_logic #(
  parameter int STAMP_BITS = 32
) (
  input  rte_pkg::in_t           item,
  input  rte_pkg::state_t        cur,
  input  logic [STAMP_BITS-1:0]  last_step,
  input  logic [15:0]            holdoff,
  output rte_pkg::state_t        nxt,
  output logic [STAMP_BITS-1:0]  last_step_nxt,
  output logic [1:0]             step
);
  import rte_pkg::*;

  logic [1:0]            pins;
  logic [1:0]            dir;
  logic [STAMP_BITS-1:0] now_stamp;
  logic [STAMP_BITS-1:0] elapsed;
  logic                  up;

  assign pins      = {item.pin_a, item.pin_b};
  assign now_stamp = STAMP_BITS'(item.now_ms);
  assign elapsed   = now_stamp - last_step;
  assign up        = (dir == STEP_UP);

  always_comb begin
    if ((cur.pins == PINS_A && pins == PINS_HIGH) || (cur.pins == PINS_B && pins == PINS_LOW)) begin
      dir = STEP_UP;
    end else if ((cur.pins == PINS_A && pins == PINS_LOW) ||
                 (cur.pins == PINS_B && pins == PINS_HIGH)) begin
      dir = STEP_DOWN;
    end else begin
      dir = STEP_NONE;
    end
  end

  always_comb begin
    nxt           = cur;
    last_step_nxt = last_step;
    step          = STEP_NONE;
    unique case (item.func)
      FUNC_CAPTURE: begin
        nxt.pins = pins;
      end
      FUNC_LOAD: begin
        nxt.hours   = item.load_hours;
        nxt.minutes = item.load_minutes;
        nxt.seconds = item.load_seconds;
      end
      FUNC_ROTATE: begin
        nxt.pins = pins;
        if (dir != STEP_NONE && elapsed > STAMP_BITS'(holdoff)) begin
          if (item.vertical_mode) begin
            nxt.pointer = up;
          end else if (item.horizontal_mode) begin
            case (item.field_select)
              SEL_HOURS:   nxt.hours   = 5'(bump({1'b0, cur.hours}, HOURS_MAX, up));
              SEL_MINUTES: nxt.minutes = bump(cur.minutes, MINUTES_MAX, up);
              SEL_SECONDS: nxt.seconds = bump(cur.seconds, MINUTES_MAX, up);
              default: ;
            endcase
          end
          last_step_nxt = now_stamp;
          step          = dir;
        end
      end
      default: ;
    endcase
  end

endmodule

>>> hw/rtl/rotary_encoder_time_setter_top.sv
// Top level of the rotary encoder time setter.
// Input register, state and result register; depends on rte_pkg and rte_step_logic.
//
// Usage:
//   in_*  : one word per encoder event (capture pins, rotation sample, load time).
//           Accepted when in_valid is high and in_stall is low.
//   out_* : exactly one result word per input word, in order: pointer, time
//           fields after the word, and the accepted step code.
//           Taken when out_valid is high and out_stall is low.
//   cfg_* : write of the 16-bit hold-off in milliseconds; cfg_ready is always
//           high. Write only while no word is in flight.
// out_valid rises once an accepted word has left the input register and its
// result is in the result register, which waits while a stalled result is held.
// One word is accepted every cycle while results are taken; the input register
// and the result register each hold one word, so in_stall rises only when both
// hold a word and out_stall is high. Stall holds the result word unchanged.
// Reset (rst_n low, synchronous) empties both registers, sets hold-off to 100,
// pins to both high, last step time, pointer and time fields to zero.
module rotary_encoder_time_setter_top #(
  parameter int STAMP_BITS = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  rte_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output rte_pkg::out_t out_data,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [15:0]   cfg_data
);
  import rte_pkg::*;

  logic                  s1_valid_r;
  in_t                   s1_data_r;
  logic                  out_valid_r;
  out_t                  out_data_r;
  state_t                state_r;
  state_t                state_nxt;
  logic [STAMP_BITS-1:0] last_step_r;
  logic [STAMP_BITS-1:0] last_step_nxt;
  logic [15:0]           holdoff_r;
  logic [1:0]            step;
  logic                  advance;
  logic                  fire;

  assign advance   = !out_valid_r || !out_stall;
  assign fire      = s1_valid_r && advance;
  assign in_stall  = s1_valid_r && !advance;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  rte_step_logic #(
    .STAMP_BITS(STAMP_BITS)
  ) u_step (
    .item         (s1_data_r),
    .cur          (state_r),
    .last_step    (last_step_r),
    .holdoff      (holdoff_r),
    .nxt          (state_nxt),
    .last_step_nxt(last_step_nxt),
    .step         (step)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      holdoff_r     <= HOLDOFF_RESET;
      state_r.pins  <= PINS_HIGH;
      state_r.pointer <= 1'b0;
      state_r.hours   <= '0;
      state_r.minutes <= '0;
      state_r.seconds <= '0;
      last_step_r   <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        holdoff_r <= cfg_data;
      end
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (fire) begin
        state_r     <= state_nxt;
        last_step_r <= last_step_nxt;
        out_valid_r <= 1'b1;
      end else if (advance) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_data_r <= in_data;
    end
    if (fire) begin
      out_data_r.menu_pointer <= state_nxt.pointer;
      out_data_r.hours        <= state_nxt.hours;
      out_data_r.minutes      <= state_nxt.minutes;
      out_data_r.seconds      <= state_nxt.seconds;
      out_data_r.step         <= step;
    end
  end

endmodule

>>> hw/rtl/rte_checker.sv
// Port-level checks for the rotary encoder time setter, bound to the top level.
// Depends on rte_pkg and rotary_encoder_time_setter_top.
module rte_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_stall,
  input rte_pkg::in_t  in_data,
  input logic          out_valid,
  input logic          out_stall,
  input rte_pkg::out_t out_data
);
  import rte_pkg::*;

  a_reset_empty : assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word present after reset");

  a_out_hold : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result word changed");

  a_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled result");

  a_load_result : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_data.func == FUNC_LOAD) ##1 (!out_valid || !out_stall)
    |=> out_valid && out_data.hours == $past(in_data.load_hours, 2) &&
        out_data.step == STEP_NONE)
    else $error("load word not reflected in result");

  a_capture_no_step : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_data.func == FUNC_CAPTURE) ##1 (!out_valid || !out_stall)
    |=> out_valid && out_data.step == STEP_NONE)
    else $error("capture word reported a step");

endmodule

bind rotary_encoder_time_setter_top rte_checker u_rte_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);
